### rtl/pt_pkg.sv
package pt_pkg;

  localparam int unsigned NumW = 63;
  localparam int unsigned CntW = $clog2(NumW + 1);
  localparam int unsigned NumBases = 5;
  localparam int unsigned BaseIdxW = $clog2(NumBases);

  typedef logic [NumW-1:0] num_t;

  // Witness bases, all well below 2^8 so any NumW in range holds them.
  function automatic num_t base_value(input logic [BaseIdxW-1:0] idx);
    num_t v;
    v = '0;
    unique case (idx)
      3'd0: v[7:0] = 8'd2;
      3'd1: v[7:0] = 8'd3;
      3'd2: v[7:0] = 8'd5;
      3'd3: v[7:0] = 8'd7;
      3'd4: v[7:0] = 8'd43;
      default: v[7:0] = 8'd2;
    endcase
    return v;
  endfunction

  typedef enum logic [1:0] {
    MulAccB,    // acc <= acc * b
    MulBB,      // b <= b * b
    MulAccAcc,  // acc <= acc * acc
    MulRedBase  // b <= 1 * base, i.e. base mod n
  } mul_op_e;

  typedef struct packed {
    logic    load_n;      // latch candidate, work out n-1, reset trailing zero count
    logic    strip_zero;  // d >>= 1, s++
    logic    load_base;   // acc = 1, e = d, squaring count cleared, scan flag set
    logic    next_base;
    logic    mul_start;
    mul_op_e mul_op;
    logic    shift_e;
    logic    step_k;      // fold acc into the scan flag, count one squaring
  } pt_cmd_t;

  typedef struct packed {
    logic d_even;
    logic mul_done;
    logic e_zero;
    logic e_lsb;
    logic k_done;         // k == s
    logic acc_one;
    logic scan_ok;        // last power other than 1 was n-1, or none seen
    logic small_prime;
    logic below_two;
    logic last_base;
  } pt_status_t;

  typedef enum logic [3:0] {
    StIdle,
    StCheck,
    StStrip,
    StBase,
    StReduce,
    StPowTest,
    StPowMulAcc,
    StPowSqB,
    StPowMulB,
    StSqTest,
    StSqWait,
    StBaseEnd,
    StDone
  } state_e;

endpackage

### rtl/pt_datapath.sv
module pt_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [pt_pkg::NumW-1:0]     candidate_i,
  input  pt_pkg::pt_cmd_t             cmd_i,
  output pt_pkg::pt_status_t          status_o
);

  pt_pkg::num_t n_q, nm1_q, d_q, e_q, acc_q, b_q, a_q, m_q, r_q;
  pt_pkg::num_t n_d, nm1_d, d_d, e_d, acc_d, b_d, a_d, m_d, r_d;
  logic [pt_pkg::CntW-1:0] s_q, s_d, k_q, k_d, bit_q, bit_d;
  logic [pt_pkg::BaseIdxW-1:0] bidx_q, bidx_d;
  logic busy_mul_q, busy_mul_d, ok_q, ok_d;
  pt_pkg::mul_op_e op_q, op_d;
  logic [pt_pkg::NumW:0] dbl, dsum, add2;
  pt_pkg::num_t r1, base_v;

  assign base_v = pt_pkg::base_value(bidx_q);

  // one shift-and-add step: r = 2r mod n, then + a if bit set
  always_comb begin
    dbl  = {r_q, 1'b0};
    r1   = (dbl >= {1'b0, n_q}) ? pt_pkg::NumW'(dbl - {1'b0, n_q}) : dbl[pt_pkg::NumW-1:0];
    dsum = {1'b0, r1} + {1'b0, a_q};
    add2 = (dsum >= {1'b0, n_q}) ? dsum - {1'b0, n_q} : dsum;
  end

  always_comb begin
    n_d = n_q; nm1_d = nm1_q; d_d = d_q; e_d = e_q; acc_d = acc_q; b_d = b_q;
    a_d = a_q; m_d = m_q; r_d = r_q; s_d = s_q; k_d = k_q; bit_d = bit_q;
    bidx_d = bidx_q; busy_mul_d = busy_mul_q; op_d = op_q; ok_d = ok_q;
    if (cmd_i.load_n) begin
      n_d = candidate_i;
      nm1_d = candidate_i - pt_pkg::NumW'(1);
      d_d = candidate_i - pt_pkg::NumW'(1);
      s_d = '0;
      bidx_d = '0;
    end
    if (cmd_i.strip_zero) begin
      d_d = d_q >> 1;
      s_d = s_q + pt_pkg::CntW'(1);
    end
    if (cmd_i.load_base) begin
      acc_d = pt_pkg::NumW'(1);
      e_d = d_q;
      k_d = '0;
      ok_d = 1'b1;
    end
    if (cmd_i.next_base) bidx_d = bidx_q + pt_pkg::BaseIdxW'(1);
    if (cmd_i.shift_e) e_d = e_q >> 1;
    if (cmd_i.step_k) begin
      k_d = k_q + pt_pkg::CntW'(1);
      // once a power is 1 all later ones are too, so the last other value decides
      if (acc_q != pt_pkg::NumW'(1)) ok_d = (acc_q == nm1_q);
    end
    if (cmd_i.mul_start) begin
      busy_mul_d = 1'b1;
      op_d = cmd_i.mul_op;
      r_d = '0;
      bit_d = pt_pkg::CntW'(pt_pkg::NumW - 1);
      unique case (cmd_i.mul_op)
        pt_pkg::MulAccB:    begin a_d = acc_q;              m_d = b_q;    end
        pt_pkg::MulBB:      begin a_d = b_q;                m_d = b_q;    end
        pt_pkg::MulAccAcc:  begin a_d = acc_q;              m_d = acc_q;  end
        pt_pkg::MulRedBase: begin a_d = pt_pkg::NumW'(1);   m_d = base_v; end
      endcase
    end else if (busy_mul_q) begin
      r_d = m_q[bit_q] ? add2[pt_pkg::NumW-1:0] : r1;
      if (bit_q == '0) begin
        busy_mul_d = 1'b0;
        unique case (op_q)
          pt_pkg::MulBB, pt_pkg::MulRedBase:  b_d = r_d;
          pt_pkg::MulAccB, pt_pkg::MulAccAcc: acc_d = r_d;
        endcase
      end else begin
        bit_d = bit_q - pt_pkg::CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_mul_q <= 1'b0;
      bidx_q <= '0;
      op_q <= pt_pkg::MulAccB;
      ok_q <= 1'b1;
      n_q <= '0; nm1_q <= '0; d_q <= '0; e_q <= '0; acc_q <= '0; b_q <= '0;
      a_q <= '0; m_q <= '0; r_q <= '0; s_q <= '0; k_q <= '0; bit_q <= '0;
    end else begin
      busy_mul_q <= busy_mul_d;
      bidx_q <= bidx_d;
      op_q <= op_d;
      ok_q <= ok_d;
      n_q <= n_d; nm1_q <= nm1_d; d_q <= d_d; e_q <= e_d; acc_q <= acc_d; b_q <= b_d;
      a_q <= a_d; m_q <= m_d; r_q <= r_d; s_q <= s_d; k_q <= k_d; bit_q <= bit_d;
    end
  end

  always_comb begin
    status_o.d_even = ~d_q[0] && (s_q < pt_pkg::CntW'(pt_pkg::NumW));
    status_o.mul_done = busy_mul_q && (bit_q == '0);
    status_o.e_zero = (e_q == '0);
    status_o.e_lsb = e_q[0];
    status_o.k_done = (k_q == s_q);
    status_o.acc_one = (acc_q == pt_pkg::NumW'(1));
    status_o.scan_ok = ok_q;
    status_o.small_prime = (n_q == pt_pkg::NumW'(2)) || (n_q == pt_pkg::NumW'(3)) ||
                           (n_q == pt_pkg::NumW'(5)) || (n_q == pt_pkg::NumW'(7)) ||
                           (n_q == pt_pkg::NumW'(43));
    status_o.below_two = (n_q < pt_pkg::NumW'(2));
    status_o.last_base = (bidx_q == pt_pkg::BaseIdxW'(pt_pkg::NumBases - 1));
  end

endmodule

### rtl/pt_ctrl.sv
module pt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  pt_pkg::pt_status_t status_i,
  output pt_pkg::pt_cmd_t    cmd_o,
  output logic               busy_o,
  output logic               done_o,
  output logic               prime_flag_o
);

  pt_pkg::state_e state_q, state_d;
  logic flag_q, flag_d;

  always_comb begin
    state_d = state_q;
    flag_d = flag_q;
    unique case (state_q)
      pt_pkg::StIdle: if (start_i) state_d = pt_pkg::StCheck;
      pt_pkg::StCheck: begin
        priority if (status_i.below_two) begin
          flag_d = 1'b0; state_d = pt_pkg::StDone;
        end else if (status_i.small_prime) begin
          flag_d = 1'b1; state_d = pt_pkg::StDone;
        end else state_d = pt_pkg::StStrip;
      end
      pt_pkg::StStrip: if (!status_i.d_even) state_d = pt_pkg::StBase;
      pt_pkg::StBase: state_d = pt_pkg::StReduce;
      pt_pkg::StReduce: if (status_i.mul_done) state_d = pt_pkg::StPowTest;
      pt_pkg::StPowTest: begin
        priority if (status_i.e_zero) state_d = pt_pkg::StSqTest;
        else if (status_i.e_lsb) state_d = pt_pkg::StPowMulAcc;
        else state_d = pt_pkg::StPowSqB;
      end
      pt_pkg::StPowMulAcc: if (status_i.mul_done) state_d = pt_pkg::StPowSqB;
      pt_pkg::StPowSqB: state_d = pt_pkg::StPowMulB;
      pt_pkg::StPowMulB: if (status_i.mul_done) state_d = pt_pkg::StPowTest;
      // square acc s times, watching each power before it is squared
      pt_pkg::StSqTest: begin
        if (status_i.k_done) state_d = pt_pkg::StBaseEnd;
        else state_d = pt_pkg::StSqWait;
      end
      pt_pkg::StSqWait: if (status_i.mul_done) state_d = pt_pkg::StSqTest;
      pt_pkg::StBaseEnd: begin
        if (status_i.acc_one && status_i.scan_ok) begin
          if (status_i.last_base) begin
            flag_d = 1'b1; state_d = pt_pkg::StDone;
          end else state_d = pt_pkg::StBase;
        end else begin
          flag_d = 1'b0; state_d = pt_pkg::StDone;
        end
      end
      pt_pkg::StDone: state_d = pt_pkg::StIdle;
      default: state_d = pt_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.mul_op = pt_pkg::MulAccB;
    unique case (state_q)
      pt_pkg::StIdle: cmd_o.load_n = start_i;
      pt_pkg::StStrip: cmd_o.strip_zero = status_i.d_even;
      pt_pkg::StBase: begin
        cmd_o.load_base = 1'b1;
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_op = pt_pkg::MulRedBase;
      end
      pt_pkg::StPowTest: begin
        if (!status_i.e_zero && status_i.e_lsb) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_op = pt_pkg::MulAccB;
        end
      end
      pt_pkg::StPowSqB: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_op = pt_pkg::MulBB;
        cmd_o.shift_e = 1'b1;
      end
      pt_pkg::StSqTest: begin
        if (!status_i.k_done) begin
          cmd_o.step_k = 1'b1;
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_op = pt_pkg::MulAccAcc;
        end
      end
      pt_pkg::StBaseEnd:
        cmd_o.next_base = status_i.acc_one && status_i.scan_ok && !status_i.last_base;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pt_pkg::StIdle;
      flag_q <= 1'b0;
    end else begin
      state_q <= state_d;
      flag_q <= flag_d;
    end
  end

  assign busy_o = (state_q != pt_pkg::StIdle);
  assign done_o = (state_q == pt_pkg::StDone);
  assign prime_flag_o = flag_q;

endmodule

### rtl/primality_test_top.sv
// Five-base strong-pseudoprime test (bases 2, 3, 5, 7, 43) on a 63-bit unsigned number.
// Raise start while busy is low to hand in one beat on candidate_i; busy then stays high
// until the verdict. prime_flag_o is valid only in the single cycle that done is high and
// must be taken then: the receiver cannot stall the block. One number is in flight at a
// time and the next beat is accepted from the cycle after done. Each modular product is a
// bit-serial shift-and-add, one launch step then one step per bit; a base needs up to
// about 127 of them. Values below 2 and the five base values go from the first check
// straight to done, and most composites stop after the first base.
module primality_test_top (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [pt_pkg::NumW-1:0] candidate_i,
  output logic                    done,
  output logic                    prime_flag_o
);

  pt_pkg::pt_cmd_t    cmd;
  pt_pkg::pt_status_t status;

  pt_datapath u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .candidate_i(candidate_i),
    .cmd_i(cmd), .status_o(status)
  );

  pt_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .status_i(status),
    .cmd_o(cmd), .busy_o(busy), .done_o(done), .prime_flag_o(prime_flag_o)
  );

endmodule

### rtl/pt_checker.sv
module pt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done
);

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) done |-> busy)
    else $error("done without busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accept did not raise busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni) done |=> !busy)
    else $error("busy after done");

endmodule

bind primality_test_top pt_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .done(done)
);
